// ----- src/abb_pkg.sv -----
package abb_pkg;

	// three spatial axes, both for input corners and output bounds
	localparam int AXES = 3;

	// integer bits of a coefficient; the rest of COEF_BITS is fraction
	localparam int COEF_INT_BITS = 4;

	// width of a configuration register index
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_X = 3'd0,
		CFG_ROW_Y = 3'd1,
		CFG_ROW_Z = 3'd2,
		CFG_OFF_X = 3'd3,
		CFG_OFF_Y = 3'd4,
		CFG_OFF_Z = 3'd5
	} cfg_idx_t;

	// pipeline depth from accepted word to done strobe
	localparam int LATENCY = 4;

endpackage

// ----- src/abb_prod.sv -----
module abb_prod #(
	parameter int COORD_BITS = 32,
	parameter int COEF_BITS  = 16
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [3*COEF_BITS-1:0]                 row,
	input  logic signed [COORD_BITS-1:0]           lo [abb_pkg::AXES],
	input  logic signed [COORD_BITS-1:0]           hi [abb_pkg::AXES],
	output logic signed [COORD_BITS+COEF_BITS-1:0] p_lo_s1 [abb_pkg::AXES],
	output logic signed [COORD_BITS+COEF_BITS-1:0] p_hi_s1 [abb_pkg::AXES]
);
	import abb_pkg::*;

	logic signed [COEF_BITS-1:0] coef [AXES];

	always_comb begin
		for (int b = 0; b < AXES; b++) begin
			coef[b] = $signed(row[b*COEF_BITS +: COEF_BITS]);
		end
	end

	// both ends of each input axis times its coefficient
	always_ff @(posedge clk) begin
		if (en) begin
			for (int b = 0; b < AXES; b++) begin
				p_lo_s1[b] <= coef[b] * lo[b];
				p_hi_s1[b] <= coef[b] * hi[b];
			end
		end
	end

endmodule

// ----- src/abb_span.sv -----
module abb_span #(
	parameter int PROD_W = 48
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [PROD_W-1:0] p_lo [abb_pkg::AXES],
	input  logic signed [PROD_W-1:0] p_hi [abb_pkg::AXES],
	output logic signed [PROD_W-1:0] mn_s2 [abb_pkg::AXES],
	output logic signed [PROD_W-1:0] mx_s2 [abb_pkg::AXES]
);
	import abb_pkg::*;

	// order each term pair; the terms are independent per axis
	always_ff @(posedge clk) begin
		if (en) begin
			for (int b = 0; b < AXES; b++) begin
				if (p_lo[b] < p_hi[b]) begin
					mn_s2[b] <= p_lo[b];
					mx_s2[b] <= p_hi[b];
				end else begin
					mn_s2[b] <= p_hi[b];
					mx_s2[b] <= p_lo[b];
				end
			end
		end
	end

endmodule

// ----- src/abb_acc.sv -----
module abb_acc #(
	parameter int COORD_BITS = 32,
	parameter int COEF_BITS  = 16
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [COORD_BITS+COEF_BITS-1:0] mn [abb_pkg::AXES],
	input  logic signed [COORD_BITS+COEF_BITS-1:0] mx [abb_pkg::AXES],
	input  logic signed [COORD_BITS-1:0]           offset,
	output logic signed [COORD_BITS+COEF_BITS+1:0] sum_lo_s3,
	output logic signed [COORD_BITS+COEF_BITS+1:0] sum_hi_s3
);
	import abb_pkg::*;

	localparam int FRAC  = COEF_BITS - COEF_INT_BITS;
	localparam int SUM_W = COORD_BITS + COEF_BITS + 2;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC - 1);

	logic signed [SUM_W-1:0] off_w;

	// offset aligned to the product scale, rounding half folded in
	assign off_w = (SUM_W'(offset) <<< FRAC) + HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_lo_s3 <= SUM_W'(mn[0]) + SUM_W'(mn[1]) + SUM_W'(mn[2]) + off_w;
			sum_hi_s3 <= SUM_W'(mx[0]) + SUM_W'(mx[1]) + SUM_W'(mx[2]) + off_w;
		end
	end

endmodule

// ----- src/abb_sat.sv -----
module abb_sat #(
	parameter int COORD_BITS = 32,
	parameter int COEF_BITS  = 16
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [COORD_BITS+COEF_BITS+1:0] sum_lo,
	input  logic signed [COORD_BITS+COEF_BITS+1:0] sum_hi,
	output logic signed [COORD_BITS-1:0]           lo_s4,
	output logic signed [COORD_BITS-1:0]           hi_s4
);
	import abb_pkg::*;

	localparam int FRAC  = COEF_BITS - COEF_INT_BITS;
	localparam int SUM_W = COORD_BITS + COEF_BITS + 2;
	localparam logic signed [SUM_W-1:0] MAXV = (SUM_W'(1) << (COORD_BITS - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] MINV = ~MAXV;

	logic signed [SUM_W-1:0] rnd_lo;
	logic signed [SUM_W-1:0] rnd_hi;

	// floor shift; the half was added upstream
	assign rnd_lo = sum_lo >>> FRAC;
	assign rnd_hi = sum_hi >>> FRAC;

	always_ff @(posedge clk) begin
		if (en) begin
			if (rnd_lo > MAXV)      lo_s4 <= MAXV[COORD_BITS-1:0];
			else if (rnd_lo < MINV) lo_s4 <= MINV[COORD_BITS-1:0];
			else                    lo_s4 <= rnd_lo[COORD_BITS-1:0];
			if (rnd_hi > MAXV)      hi_s4 <= MAXV[COORD_BITS-1:0];
			else if (rnd_hi < MINV) hi_s4 <= MINV[COORD_BITS-1:0];
			else                    hi_s4 <= rnd_hi[COORD_BITS-1:0];
		end
	end

endmodule

// ----- src/affine_box_bounds.sv -----
// affine_box_bounds: axis-aligned bounds of an affinely mapped box.
// Throughput: one box word per cycle; busy never rises, no stall is possible.
// Results come one per done pulse and cannot be held off by the receiver.
// Reset (arst_n low, async) clears all config registers to 0 and empties the pipe.
module affine_box_bounds #(
	parameter int COORD_BITS = 32,
	parameter int COEF_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command channel
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_BITS-1:0]  lo_x,
	input  logic signed [COORD_BITS-1:0]  lo_y,
	input  logic signed [COORD_BITS-1:0]  lo_z,
	input  logic signed [COORD_BITS-1:0]  hi_x,
	input  logic signed [COORD_BITS-1:0]  hi_y,
	input  logic signed [COORD_BITS-1:0]  hi_z,
	// result channel
	output logic                          done,
	output logic signed [COORD_BITS-1:0]  out_lo_x,
	output logic signed [COORD_BITS-1:0]  out_lo_y,
	output logic signed [COORD_BITS-1:0]  out_lo_z,
	output logic signed [COORD_BITS-1:0]  out_hi_x,
	output logic signed [COORD_BITS-1:0]  out_hi_y,
	output logic signed [COORD_BITS-1:0]  out_hi_z,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [abb_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [((3*COEF_BITS > COORD_BITS) ? 3*COEF_BITS : COORD_BITS)-1:0] cfg_wdata
);
	import abb_pkg::*;

	// Microarchitecture
	// The mapped corners' min and max split per input axis: for each output
	// axis, min over corners of sum(c*v) is sum over input axes of
	// min(c*lo, c*hi), and the same for max. Rounding and saturation are
	// monotone, so they can follow the summation.
	//   s1: 18 products, coefficient times both ends of each input axis
	//   s2: order each product pair into min and max terms
	//   s3: add the three terms, the scaled offset and the rounding half
	//   s4: floor shift, saturate to the coordinate range, drive outputs
	// A valid bit per stage rides along with the word; every stage advances
	// each cycle since nothing downstream can stall.

	localparam int ROW_W  = 3 * COEF_BITS;
	localparam int PROD_W = COORD_BITS + COEF_BITS;
	localparam int SUM_W  = PROD_W + 2;

	// configuration registers
	logic [ROW_W-1:0]             row_q [AXES];
	logic signed [COORD_BITS-1:0] off_q [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				row_q[a] <= '0;
				off_q[a] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ROW_X: row_q[0] <= cfg_wdata[ROW_W-1:0];
				CFG_ROW_Y: row_q[1] <= cfg_wdata[ROW_W-1:0];
				CFG_ROW_Z: row_q[2] <= cfg_wdata[ROW_W-1:0];
				CFG_OFF_X: off_q[0] <= $signed(cfg_wdata[COORD_BITS-1:0]);
				CFG_OFF_Y: off_q[1] <= $signed(cfg_wdata[COORD_BITS-1:0]);
				CFG_OFF_Z: off_q[2] <= $signed(cfg_wdata[COORD_BITS-1:0]);
				default: ; // unknown index: write dropped
			endcase
		end
	end

	// a word is taken every cycle start is high
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign done = vld_s4;

	logic signed [COORD_BITS-1:0] lo_in [AXES];
	logic signed [COORD_BITS-1:0] hi_in [AXES];

	assign lo_in[0] = lo_x;
	assign lo_in[1] = lo_y;
	assign lo_in[2] = lo_z;
	assign hi_in[0] = hi_x;
	assign hi_in[1] = hi_y;
	assign hi_in[2] = hi_z;

	logic signed [COORD_BITS-1:0] res_lo [AXES];
	logic signed [COORD_BITS-1:0] res_hi [AXES];

	// one lane per output axis
	for (genvar a = 0; a < AXES; a++) begin : g_axis
		logic signed [PROD_W-1:0] p_lo_s1 [AXES];
		logic signed [PROD_W-1:0] p_hi_s1 [AXES];
		logic signed [PROD_W-1:0] mn_s2   [AXES];
		logic signed [PROD_W-1:0] mx_s2   [AXES];
		logic signed [SUM_W-1:0]  sum_lo_s3;
		logic signed [SUM_W-1:0]  sum_hi_s3;

		abb_prod #(
			.COORD_BITS(COORD_BITS),
			.COEF_BITS (COEF_BITS)
		) u_prod (
			.clk    (clk),
			.en     (accept),
			.row    (row_q[a]),
			.lo     (lo_in),
			.hi     (hi_in),
			.p_lo_s1(p_lo_s1),
			.p_hi_s1(p_hi_s1)
		);

		abb_span #(
			.PROD_W(PROD_W)
		) u_span (
			.clk  (clk),
			.en   (vld_s1),
			.p_lo (p_lo_s1),
			.p_hi (p_hi_s1),
			.mn_s2(mn_s2),
			.mx_s2(mx_s2)
		);

		abb_acc #(
			.COORD_BITS(COORD_BITS),
			.COEF_BITS (COEF_BITS)
		) u_acc (
			.clk      (clk),
			.en       (vld_s2),
			.mn       (mn_s2),
			.mx       (mx_s2),
			.offset   (off_q[a]),
			.sum_lo_s3(sum_lo_s3),
			.sum_hi_s3(sum_hi_s3)
		);

		abb_sat #(
			.COORD_BITS(COORD_BITS),
			.COEF_BITS (COEF_BITS)
		) u_sat (
			.clk   (clk),
			.en    (vld_s3),
			.sum_lo(sum_lo_s3),
			.sum_hi(sum_hi_s3),
			.lo_s4 (res_lo[a]),
			.hi_s4 (res_hi[a])
		);
	end

	assign out_lo_x = res_lo[0];
	assign out_lo_y = res_lo[1];
	assign out_lo_z = res_lo[2];
	assign out_hi_x = res_hi[0];
	assign out_hi_y = res_hi[1];
	assign out_hi_z = res_hi[2];

	// every accepted word comes out with a done strobe at the end of the pipe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("accepted word did not produce done after 4 cycles");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("done without a matching accepted word");

	// min term never exceeds max term, so bounds are always ordered
	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_lo_x <= out_hi_x) && (out_lo_y <= out_hi_y)
			&& (out_lo_z <= out_hi_z))
		else $error("result bounds out of order");

endmodule

// ----- dv/testbench.sv -----
module testbench;

	import abb_pkg::*;

	// Block sizes (the block's defaults)
	localparam int COORD_BITS = 32;
	localparam int COEF_BITS  = 16;
	localparam int COEF_FRAC  = COEF_BITS - COEF_INT_BITS;
	localparam int ROW_W      = 3 * COEF_BITS;
	localparam int CFG_W      = (ROW_W > COORD_BITS) ? ROW_W : COORD_BITS;
	// Exact sum of three products plus the shifted offset fits here with room to spare
	localparam int ACC_W      = COORD_BITS + COEF_BITS + 4;

	// Run length
	localparam int BOXES_PER_PHASE = 120;
	localparam int RANDOM_PHASES   = 8;
	localparam int WATCHDOG_LIMIT  = 2000;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COEF_BITS-1:0]  coef_t;
	typedef logic [ROW_W-1:0]             row_t;

	typedef struct packed {
		coord_t lo_x;
		coord_t lo_y;
		coord_t lo_z;
		coord_t hi_x;
		coord_t hi_y;
		coord_t hi_z;
	} box_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam coef_t  COEF_MAX  = {1'b0, {(COEF_BITS-1){1'b1}}};
	localparam coef_t  COEF_MIN  = {1'b1, {(COEF_BITS-1){1'b0}}};
	localparam coef_t  COEF_ONE  = coef_t'(1) <<< COEF_FRAC;
	localparam coef_t  COEF_HALF = coef_t'(1) <<< (COEF_FRAC - 1);
	localparam coef_t  COEF_ULP  = coef_t'(1);
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);

	// Register indexes past the end of the map; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(CFG_OFF_Z) + 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(CFG_OFF_Z) + 2'd2;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	coord_t lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
	logic done;
	coord_t out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	affine_box_bounds #(
		.COORD_BITS(COORD_BITS),
		.COEF_BITS (COEF_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.lo_x     (lo_x),
		.lo_y     (lo_y),
		.lo_z     (lo_z),
		.hi_x     (hi_x),
		.hi_y     (hi_y),
		.hi_z     (hi_z),
		.done     (done),
		.out_lo_x (out_lo_x),
		.out_lo_y (out_lo_y),
		.out_lo_z (out_lo_z),
		.out_hi_x (out_hi_x),
		.out_hi_y (out_hi_y),
		.out_hi_z (out_hi_z),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow of the transform registers, updated on the same edge as the block's
	row_t   row_shadow [3];
	coord_t off_shadow [3];

	// Bounds predicted for accepted words, oldest first
	box_t pending_bounds [$];

	int mismatch_count = 0;
	int stall_cycles = 0;

	// Sender pacing: bursts of back-to-back words separated by random gaps
	bit gaps_on = 1'b0;
	int burst_left = 0;

	//------------------------------------------------------------------------
	// Predictor
	//------------------------------------------------------------------------

	// One output coordinate of one corner: exact dot product plus offset,
	// round half up from the Q4.12 coefficient scale to an integer, then clamp to the coordinate range.
	function automatic coord_t map_axis(row_t row, coord_t off, coord_t x, coord_t y,
			coord_t z);
		logic signed [ACC_W-1:0] acc;
		coef_t cx, cy, cz;
		cx = row[COEF_BITS-1:0];
		cy = row[2*COEF_BITS-1:COEF_BITS];
		cz = row[3*COEF_BITS-1:2*COEF_BITS];
		acc = ACC_W'(off);
		acc = acc <<< COEF_FRAC;
		acc = acc + cx * x + cy * y + cz * z + ROUND_HALF;
		acc = acc >>> COEF_FRAC;
		// in range when every bit above the coordinate's sign matches it
		if (&acc[ACC_W-1:COORD_BITS-1] || ~|acc[ACC_W-1:COORD_BITS-1])
			return acc[COORD_BITS-1:0];
		return acc[ACC_W-1] ? COORD_MIN : COORD_MAX;
	endfunction

	// Bounds over all eight corners; an inverted box needs no special handling
	// since the corners are picked per axis from lo or hi either way.
	function automatic box_t bound_box(box_t b);
		coord_t mn [3];
		coord_t mx [3];
		coord_t v, x, y, z;
		box_t r;
		for (int c = 0; c < 8; c++) begin
			x = c[0] ? b.hi_x : b.lo_x;
			y = c[1] ? b.hi_y : b.lo_y;
			z = c[2] ? b.hi_z : b.lo_z;
			for (int a = 0; a < AXES; a++) begin
				v = map_axis(row_shadow[a], off_shadow[a], x, y, z);
				if (c == 0 || v < mn[a])
					mn[a] = v;
				if (c == 0 || v > mx[a])
					mx[a] = v;
			end
		end
		r.lo_x = mn[0];
		r.lo_y = mn[1];
		r.lo_z = mn[2];
		r.hi_x = mx[0];
		r.hi_y = mx[1];
		r.hi_z = mx[2];
		return r;
	endfunction

	task automatic check_field(string name, coord_t want, coord_t got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	//------------------------------------------------------------------------
	// Monitor: shadow config, predict on accept, check on done, watchdog.
	// Everything is sampled at the rising edge, before this edge's updates.
	//------------------------------------------------------------------------
	always @(posedge clk) begin
		box_t word_in;
		box_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_ROW_X: row_shadow[0] = cfg_wdata[ROW_W-1:0];
					CFG_ROW_Y: row_shadow[1] = cfg_wdata[ROW_W-1:0];
					CFG_ROW_Z: row_shadow[2] = cfg_wdata[ROW_W-1:0];
					CFG_OFF_X: off_shadow[0] = cfg_wdata[COORD_BITS-1:0];
					CFG_OFF_Y: off_shadow[1] = cfg_wdata[COORD_BITS-1:0];
					CFG_OFF_Z: off_shadow[2] = cfg_wdata[COORD_BITS-1:0];
					default: ;
				endcase
			end

			if (start && !busy) begin
				word_in = {lo_x, lo_y, lo_z, hi_x, hi_y, hi_z};
				pending_bounds.push_back(bound_box(word_in));
			end

			if (done) begin
				if (pending_bounds.size() == 0) begin
					$error("done strobe with no box outstanding");
					mismatch_count++;
				end else begin
					want = pending_bounds.pop_front();
					check_field("out_lo_x", want.lo_x, out_lo_x);
					check_field("out_lo_y", want.lo_y, out_lo_y);
					check_field("out_lo_z", want.lo_z, out_lo_z);
					check_field("out_hi_x", want.hi_x, out_hi_x);
					check_field("out_hi_y", want.hi_y, out_hi_y);
					check_field("out_hi_z", want.hi_z, out_hi_z);
				end
			end

			// watchdog: any accepted word, result or register write is progress
			if ((start && !busy) || done || cfg_we)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	//------------------------------------------------------------------------
	// Driving helpers (called at a rising edge, drive with NBAs)
	//------------------------------------------------------------------------

	// Offers one word and returns at the edge that accepts it; start is left
	// high so a following word can go out back to back.
	task automatic send_box(box_t b);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 16);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		start <= 1'b1;
		lo_x  <= b.lo_x;
		lo_y  <= b.lo_y;
		lo_z  <= b.lo_z;
		hi_x  <= b.hi_x;
		hi_y  <= b.hi_y;
		hi_z  <= b.hi_z;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Stop sending and let every outstanding box come back, plus pipe slack.
	task automatic wait_idle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_bounds.size() != 0);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	function automatic row_t pack_row(coef_t cx, coef_t cy, coef_t cz);
		return {cz, cy, cx};
	endfunction

	// Full reprogram of the transform. Offsets carry junk above their width,
	// which the block must drop.
	task automatic set_transform(row_t rx, row_t ry, row_t rz, coord_t ox, coord_t oy,
			coord_t oz);
		wait_idle();
		write_reg(CFG_ROW_X, rx);
		write_reg(CFG_ROW_Y, ry);
		write_reg(CFG_ROW_Z, rz);
		write_reg(CFG_OFF_X, {(CFG_W-COORD_BITS)'($urandom()), ox});
		write_reg(CFG_OFF_Y, {(CFG_W-COORD_BITS)'($urandom()), oy});
		write_reg(CFG_OFF_Z, {(CFG_W-COORD_BITS)'($urandom()), oz});
	endtask

	task automatic set_identity(coord_t ox, coord_t oy, coord_t oz);
		set_transform(pack_row(COEF_ONE, 0, 0), pack_row(0, COEF_ONE, 0),
			pack_row(0, 0, COEF_ONE), ox, oy, oz);
	endtask

	function automatic box_t make_box(coord_t lx, coord_t ly, coord_t lz, coord_t hx,
			coord_t hy, coord_t hz);
		return {lx, ly, lz, hx, hy, hz};
	endfunction

	//------------------------------------------------------------------------
	// Random value sources
	//------------------------------------------------------------------------

	// Mostly modest coordinates so products stay in range; some full-range
	// and edge values to push saturation.
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 7))
			0, 1:    return coord_t'($urandom());
			2:       return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
			default: return coord_t'($urandom_range(0, 2097152)) - coord_t'(1048576);
		endcase
	endfunction

	function automatic coef_t rand_coef();
		case ($urandom_range(0, 5))
			0, 1: return coef_t'($urandom());
			2: begin
				case ($urandom_range(0, 4))
					0: return COEF_MAX;
					1: return COEF_MIN;
					2: return COEF_ONE;
					3: return -COEF_ONE;
					default: return '0;
				endcase
			end
			default: return coef_t'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE;
		endcase
	endfunction

	function automatic coord_t rand_offset();
		return $urandom_range(0, 1) ? coord_t'($urandom())
			: coord_t'($urandom_range(0, 4194304)) - coord_t'(2097152);
	endfunction

	// Mostly proper boxes (lo <= hi); some inverted, some collapsed to a point.
	function automatic box_t rand_box();
		box_t b;
		coord_t t;
		b = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord()};
		case ($urandom_range(0, 9))
			8: ;    // leave as drawn, any order
			9: begin
				b.hi_x = b.lo_x;
				b.hi_y = b.lo_y;
				b.hi_z = b.lo_z;
			end
			default: begin
				if (b.lo_x > b.hi_x) begin t = b.lo_x; b.lo_x = b.hi_x; b.hi_x = t; end
				if (b.lo_y > b.hi_y) begin t = b.lo_y; b.lo_y = b.hi_y; b.hi_y = t; end
				if (b.lo_z > b.hi_z) begin t = b.lo_z; b.lo_z = b.hi_z; b.hi_z = t; end
			end
		endcase
		return b;
	endfunction

	//------------------------------------------------------------------------
	// Tests
	//------------------------------------------------------------------------

	// Registers reset to zero: everything maps to the origin.
	task automatic test_reset_config();
		send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
			COORD_MAX));
		send_box(make_box(COORD_MAX, -1, 0, COORD_MIN, 1, -1));
	endtask

	// Identity: bounds equal the box, inverted boxes come back sorted.
	task automatic test_identity();
		set_identity(0, 0, 0);
		send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
			COORD_MAX));
		send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
			COORD_MIN));
		send_box(make_box(1, -1, 0, 1, -1, 0));
		send_box(make_box(0, 0, 0, 0, 0, 0));
		send_box(make_box(-1, -1, -1, -1, -1, -1));
	endtask

	// Largest coefficients and offsets against full-range boxes: both clamps.
	task automatic test_saturation();
		set_transform(pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
			pack_row(COEF_MIN, COEF_MIN, COEF_MIN),
			pack_row(COEF_MAX, COEF_MIN, '0), COORD_MAX, COORD_MIN, 0);
		send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
			COORD_MAX));
		send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
			COORD_MIN));
		send_box(make_box(0, 0, 0, 0, 0, 0));
		send_box(make_box(-3, 5, -7, 2, 9, 4));
	endtask

	// Half-ulp results round toward +inf: +0.5 -> 1, -0.5 -> 0.
	task automatic test_rounding();
		set_transform(pack_row(COEF_HALF, 0, 0), pack_row(0, -COEF_HALF, 0),
			pack_row(0, 0, COEF_ULP), 0, 0, 0);
		send_box(make_box(-1, -1, -2048, 1, 1, 2048));
		send_box(make_box(-1, -1, 2047, -1, -1, 2047));
		send_box(make_box(-3, 3, -2049, 3, -3, 6143));
	endtask

	// Writes to unmapped indexes must leave the transform alone.
	task automatic test_register_decode();
		set_identity(COORD_MAX, -1, COORD_MIN);
		write_reg(CFG_SPARE_A, '1);
		write_reg(CFG_SPARE_B, CFG_W'({$urandom(), $urandom()}));
		send_box(make_box(0, 0, 0, 0, 0, 0));
		send_box(make_box(-100, -100, 100, 100, 100, 100));
		send_box(make_box(COORD_MIN, 1, COORD_MAX, -1, COORD_MAX, COORD_MIN));
	endtask

	// Random boxes over several transforms, with and without sender gaps.
	task automatic test_random_phases();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: set_identity(rand_offset(), rand_offset(), rand_offset());
				1: set_transform('1, '1, '1, COORD_MAX, COORD_MAX, COORD_MAX);
				2: set_transform('0, '0, '0, COORD_MIN, COORD_MIN, COORD_MIN);
				default: set_transform(
					pack_row(rand_coef(), rand_coef(), rand_coef()),
					pack_row(rand_coef(), rand_coef(), rand_coef()),
					pack_row(rand_coef(), rand_coef(), rand_coef()),
					rand_offset(), rand_offset(), rand_offset());
			endcase
			// every third phase streams back to back
			gaps_on = (phase % 3) != 0;
			burst_left = 0;
			for (int n = 0; n < BOXES_PER_PHASE; n++)
				send_box(rand_box());
		end
	endtask

	//------------------------------------------------------------------------
	// Sequence
	//------------------------------------------------------------------------
	initial begin
		for (int a = 0; a < AXES; a++) begin
			row_shadow[a] = '0;
			off_shadow[a] = '0;
		end
		arst_n    = 1'b0;
		start     = 1'b0;
		lo_x      = '0;
		lo_y      = '0;
		lo_z      = '0;
		hi_x      = '0;
		hi_y      = '0;
		hi_z      = '0;
		cfg_we    = 1'b0;
		cfg_idx   = '0;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_identity();
		test_saturation();
		test_rounding();
		test_register_decode();
		test_random_phases();

		wait_idle();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
